// File: hdl/rgbhsl_pkg.sv
// Shared constants for the RGB to HSL converter.
// No dependencies; used by the top level for its parameter defaults.
`default_nettype none

package rgbhsl_pkg;

  // Default width of one colour channel
  localparam int CHANNEL_BITS_DEF  = 8;
  // Default width of each hue, saturation and lightness fraction
  localparam int FRACTION_BITS_DEF = 16;

endpackage

`default_nettype wire

// File: hdl/rgbhsl_front.sv
// Front end of the RGB to HSL converter: extremes, sector, hue numerator and divisors.
// Two register stages; no package dependencies.
`default_nettype none

module rgbhsl_front #(
  parameter int CB = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [CB-1:0] red,
  input  logic [CB-1:0] green,
  input  logic [CB-1:0] blue,
  output logic          out_valid,
  output logic [CB:0]   sum,
  output logic [CB:0]   sat_num,
  output logic [CB:0]   sat_den,
  output logic [CB+2:0] hue_num,
  output logic [CB+2:0] hue_den,
  output logic          grey
);

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // Full intensity and twice full intensity
  localparam logic [CB:0] FULL     = {1'b0, {CB{1'b1}}};
  localparam logic [CB:0] TWO_FULL = {{CB{1'b1}}, 1'b0};

  // Stage A registers
  logic          a_valid;
  logic [CB-1:0] a_r, a_g, a_b, a_mx, a_mn;
  sector_t       a_sec;

  logic [CB-1:0] mx_rg, mn_rg, mx_c, mn_c;
  sector_t       sec_c;

  // Find the extremes and pick the sector, red first on ties
  always_comb begin
    mx_rg = (red > green) ? red : green;
    mn_rg = (red < green) ? red : green;
    mx_c  = (blue > mx_rg) ? blue : mx_rg;
    mn_c  = (blue < mn_rg) ? blue : mn_rg;
    if (red == mx_c) begin
      sec_c = SEC_RED;
    end else if (green == mx_c) begin
      sec_c = SEC_GREEN;
    end else begin
      sec_c = SEC_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r   <= red;
      a_g   <= green;
      a_b   <= blue;
      a_mx  <= mx_c;
      a_mn  <= mn_c;
      a_sec <= sec_c;
    end
  end

  // Stage B: sum, delta, saturation divisor, hue numerator and hue divisor
  logic [CB-1:0] d_c;
  logic [CB:0]   sum_c, den_c;
  logic [CB+3:0] d6_c, hs_c;

  always_comb begin
    d_c   = a_mx - a_mn;
    sum_c = {1'b0, a_mx} + {1'b0, a_mn};
    den_c = (sum_c < FULL) ? sum_c : (TWO_FULL - sum_c);
    d6_c  = ({4'b0, d_c} << 2) + ({4'b0, d_c} << 1);
    case (a_sec)
      SEC_GREEN: hs_c = ({4'b0, d_c} << 1) + {4'b0, a_b} - {4'b0, a_r};
      SEC_BLUE:  hs_c = ({4'b0, d_c} << 2) + {4'b0, a_r} - {4'b0, a_g};
      default:   hs_c = {4'b0, a_g} - {4'b0, a_b};
    endcase
    // Wrap a negative red-sector hue by one full turn
    if (hs_c[CB+3]) begin
      hs_c = hs_c + d6_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum     <= sum_c;
      sat_num <= {1'b0, d_c};
      sat_den <= den_c;
      hue_num <= hs_c[CB+2:0];
      hue_den <= d6_c[CB+2:0];
      grey    <= (d_c == '0);
    end
  end

endmodule

`default_nettype wire

// File: hdl/rgbhsl_div.sv
// Pipelined restoring divider: quotient of num * 2^FB by dvs, with num <= dvs.
// One quotient bit per stage, FB + 1 stages; no package dependencies.
`default_nettype none

module rgbhsl_div #(
  parameter int DW = 9,
  parameter int FB = 16
) (
  input  logic          clk,
  input  logic          adv,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] dvs,
  output logic [FB:0]   quo,
  output logic [DW-1:0] rem
);

  logic [DW-1:0] rem_s [0:FB];
  logic [DW-1:0] dvs_s [0:FB];
  logic [FB:0]   quo_s [0:FB];

  // Integer bit: the numerator never exceeds the divisor
  always_ff @(posedge clk) begin
    if (adv) begin
      dvs_s[0] <= dvs;
      if (num >= dvs) begin
        rem_s[0] <= num - dvs;
        quo_s[0] <= {{FB{1'b0}}, 1'b1};
      end else begin
        rem_s[0] <= num;
        quo_s[0] <= '0;
      end
    end
  end

  // Fraction bits: shift, compare and subtract once per stage
  for (genvar k = 1; k <= FB; k++) begin : g_stage
    logic [DW:0]   rem2;
    logic          ge;
    logic [DW-1:0] rem_n;

    always_comb begin
      rem2  = {rem_s[k-1], 1'b0};
      ge    = (rem2 >= {1'b0, dvs_s[k-1]});
      rem_n = ge ? DW'(rem2 - {1'b0, dvs_s[k-1]}) : rem2[DW-1:0];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dvs_s[k] <= dvs_s[k-1];
        rem_s[k] <= rem_n;
        quo_s[k] <= {quo_s[k-1][FB-1:0], ge};
      end
    end
  end

  assign quo = quo_s[FB];
  assign rem = rem_s[FB];

endmodule

`default_nettype wire

// File: hdl/rgbhsl_skid.sv
// Output register with skid stage for the RGB to HSL converter.
// Parts the pipeline from the result channel; no package dependencies.
`default_nettype none

module rgbhsl_skid #(
  parameter int W = 48
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [W-1:0] in_data,
  output logic         adv,
  output logic         tvalid,
  input  logic         tready,
  output logic [W-1:0] tdata
);

  logic         out_valid, skid_valid;
  logic [W-1:0] out_data, skid_data;

  // Load the output register, park a transaction in the skid stage on a stall
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!skid_valid) begin
      if (!out_valid || tready) begin
        out_valid <= in_valid;
      end else if (in_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (tready) begin
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      if (!out_valid || tready) begin
        out_data <= in_data;
      end else begin
        skid_data <= in_data;
      end
    end else if (tready) begin
      out_data <= skid_data;
    end
  end

  // Freeze the pipeline while the skid stage is occupied
  assign adv    = !skid_valid;
  assign tvalid = out_valid;
  assign tdata  = out_data;

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage occupied while output register empty");

  a_stall_parks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !tready && in_valid && !skid_valid) |=> skid_valid)
    else $error("transaction dropped on output stall");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && tready) |=> (!skid_valid && out_valid && $past(skid_data) == out_data))
    else $error("skid stage failed to drain into output register");
`endif

endmodule

`default_nettype wire

// File: hdl/rgb_to_hsl_converter.sv
// RGB to HSL converter, one pixel per clock unless stalled. A pixel with red, green and blue
// channels of CHANNEL_BITS bits (all ones is full intensity) enters on the s_ side and
// leaves as hue, saturation and lightness, unsigned fractions of FRACTION_BITS bits,
// every quotient truncated; a grey pixel gives hue 0 and saturation 0, and 1.0 is
// clamped to all ones. A new pixel is taken every cycle that s_tready is high; a result
// passes through two front-end stages, the FRACTION_BITS + 1 stages of the bit-per-stage
// dividers, one result stage and the output register. A stall on the m_ side is absorbed
// by a skid stage before s_tready falls.
// Depends on rgbhsl_pkg, rgbhsl_front, rgbhsl_div and rgbhsl_skid.
`default_nettype none

module rgb_to_hsl_converter #(
  parameter int CHANNEL_BITS  = rgbhsl_pkg::CHANNEL_BITS_DEF,
  parameter int FRACTION_BITS = rgbhsl_pkg::FRACTION_BITS_DEF,
  localparam int S_W = ((3 * CHANNEL_BITS + 7) / 8) * 8,
  localparam int M_W = ((3 * FRACTION_BITS + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [S_W-1:0] s_tdata,   // red, green, blue from bit 0 up, zero padded
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [M_W-1:0] m_tdata    // hue, saturation, lightness from bit 0 up, zero padded
);

  localparam int CB = CHANNEL_BITS;
  localparam int FB = FRACTION_BITS;

  // Lightness by reciprocal: sum * (2^FB - 1) / (2 * full), exact over the whole sum range
  localparam int     LN_W   = CB + 1 + FB;
  localparam int     LIG_SH = 2 * CB + FB + 2;
  localparam int     K_W    = CB + FB + 3;
  localparam int     P_W    = LN_W + K_W;
  localparam longint LIG_D  = 2 * ((longint'(1) << CB) - 1);
  localparam longint LIG_K  = ((longint'(1) << LIG_SH) + LIG_D - 1) / LIG_D;
  localparam logic [K_W-1:0] LIG_KV = K_W'(LIG_K);

  logic adv;

  // Front end
  logic          f_valid, f_grey;
  logic [CB:0]   f_sum, f_sat_num, f_sat_den;
  logic [CB+2:0] f_hue_num, f_hue_den;

  rgbhsl_front #(.CB(CB)) u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (s_tvalid),
    .red      (s_tdata[CB-1:0]),
    .green    (s_tdata[2*CB-1:CB]),
    .blue     (s_tdata[3*CB-1:2*CB]),
    .out_valid(f_valid),
    .sum      (f_sum),
    .sat_num  (f_sat_num),
    .sat_den  (f_sat_den),
    .hue_num  (f_hue_num),
    .hue_den  (f_hue_den),
    .grey     (f_grey)
  );

  // Dividers for hue and saturation
  logic [FB:0]   hue_q, sat_q;
  logic [CB+2:0] hue_r;
  logic [CB:0]   sat_r;

  rgbhsl_div #(.DW(CB + 3), .FB(FB)) u_div_hue (
    .clk(clk), .adv(adv), .num(f_hue_num), .dvs(f_hue_den), .quo(hue_q), .rem(hue_r)
  );

  rgbhsl_div #(.DW(CB + 1), .FB(FB)) u_div_sat (
    .clk(clk), .adv(adv), .num(f_sat_num), .dvs(f_sat_den), .quo(sat_q), .rem(sat_r)
  );

  // Carry valid and grey flag alongside the dividers; lightness takes the same number of stages
  logic          sd_valid [0:FB];
  logic          sd_grey  [0:FB];
  logic [LN_W-1:0] lig_n;
  logic [P_W-1:0]  lig_p;
  logic [FB-1:0]   sd_lig [2:FB];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= FB; i++) begin
        sd_valid[i] <= 1'b0;
      end
    end else if (adv) begin
      sd_valid[0] <= f_valid;
      for (int i = 1; i <= FB; i++) begin
        sd_valid[i] <= sd_valid[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_grey[0] <= f_grey;
      lig_n      <= {f_sum, {FB{1'b0}}} - {{FB{1'b0}}, f_sum};
      lig_p      <= lig_n * LIG_KV;
      sd_lig[2]  <= lig_p[LIG_SH +: FB];
      for (int i = 1; i <= FB; i++) begin
        sd_grey[i] <= sd_grey[i-1];
      end
      for (int i = 3; i <= FB; i++) begin
        sd_lig[i] <= sd_lig[i-1];
      end
    end
  end

  // Result stage: clamp and mask grey
  logic [FB-1:0] hue_c, sat_c, lig_c;
  logic          fin_valid;
  logic [M_W-1:0] fin_data;

  always_comb begin
    hue_c = hue_q[FB] ? {FB{1'b1}} : hue_q[FB-1:0];
    sat_c = sat_q[FB] ? {FB{1'b1}} : sat_q[FB-1:0];
    if (sd_grey[FB]) begin
      hue_c = '0;
      sat_c = '0;
    end
    lig_c = sd_lig[FB];
    // hue_r and sat_r remainders are not needed
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (adv) begin
      fin_valid <= sd_valid[FB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_data <= M_W'({lig_c, sat_c, hue_c});
    end
  end

  rgbhsl_skid #(.W(M_W)) u_skid (
    .clk     (clk),
    .rst     (rst),
    .in_valid(fin_valid),
    .in_data (fin_data),
    .adv     (adv),
    .tvalid  (m_tvalid),
    .tready  (m_tready),
    .tdata   (m_tdata)
  );

  assign s_tready = adv;

endmodule

`default_nettype wire
